/* rtl/core/text_tokenizer_macros.svh */
// Assertion macros for the text tokenizer.
// Included by the files that carry concurrent assertions; needs no package.
`ifndef TEXT_TOKENIZER_MACROS_SVH
`define TEXT_TOKENIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTOK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ttok_pkg.sv */
// Shared types, codes and character constants of the text tokenizer.
// Used by text_tokenizer and its testbench; depends on nothing else.
package ttok_pkg;

   localparam int LINE_BITS = 20;
   localparam int COL_BITS  = 16;

   // Result kinds.
   localparam logic [1:0] K_CHAR  = 2'd0;
   localparam logic [1:0] K_DONE  = 2'd1;
   localparam logic [1:0] K_ERROR = 2'd2;

   // Token types.
   localparam logic [2:0] T_NUM   = 3'd0;
   localparam logic [2:0] T_IDENT = 3'd1;
   localparam logic [2:0] T_STR   = 3'd2;
   localparam logic [2:0] T_OP    = 3'd3;
   localparam logic [2:0] T_NL    = 3'd4;

   // Error codes.
   localparam logic [1:0] E_BAD_NUMBER   = 2'd0;
   localparam logic [1:0] E_BAD_ESCAPE   = 2'd1;
   localparam logic [1:0] E_OPEN_STRING  = 2'd2;

   // Scanner modes.
   localparam logic [2:0] M_IDLE     = 3'd0;
   localparam logic [2:0] M_SLASH    = 3'd1;
   localparam logic [2:0] M_LCOMMENT = 3'd2;
   localparam logic [2:0] M_BCOMMENT = 3'd3;
   localparam logic [2:0] M_STRING   = 3'd4;
   localparam logic [2:0] M_ESCAPE   = 3'd5;
   localparam logic [2:0] M_NUMBER   = 3'd6;
   localparam logic [2:0] M_IDENT    = 3'd7;

   // Characters.
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_B   = 8'h62;
   localparam logic [7:0] CH_LO_E   = 8'h65;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_LO_N   = 8'h6E;
   localparam logic [7:0] CH_LO_R   = 8'h72;
   localparam logic [7:0] CH_LO_T   = 8'h74;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [2:0]           token_type;
      logic [7:0]           text_byte;
      logic [1:0]           error_code;
      logic [LINE_BITS-1:0] line_no;
      logic [COL_BITS-1:0]  col_no;
      logic                 last_of_run;
   } rsp_payload_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CH_0:CH_9]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
   endfunction

   // Result without position; the position is filled in when results are queued.
   function automatic rsp_payload_type make_rsp(input logic [1:0] kind,
                                                input logic [2:0] ttype,
                                                input logic [7:0] tbyte,
                                                input logic [1:0] err);
      rsp_payload_type r;
      r             = '0;
      r.kind        = kind;
      r.token_type  = ttype;
      r.text_byte   = tbyte;
      r.error_code  = err;
      return r;
   endfunction

endpackage

/* rtl/core/text_tokenizer.sv */
// Streaming lexer for a JSON-like text format: one byte per request in,
// token events out. Depends on ttok_pkg and text_tokenizer_macros.svh.

// The tokenizer takes one source byte (or an end-of-input marker) per request and
// answers with zero to four results: token characters, token-done marks and errors,
// each stamped with the line and column after that byte. All scanning is done
// combinationally from the registered scanner state, and the results of a request are
// loaded into a four-entry result buffer that feeds the response port one result per
// cycle while rsp_ready is high. A new request is taken while the previous result is
// being handed out, and requests are held off until the buffer is down to its last
// result. After an error the block accepts and drops every request until reset.
`include "text_tokenizer_macros.svh"

module text_tokenizer
   import ttok_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic [2:0]           mode_ff, mode_in;
   logic                 seen_dot_ff, seen_dot_in;
   logic                 seen_exp_ff, seen_exp_in;
   logic                 sign_ok_ff, sign_ok_in;
   logic                 star_seen_ff, star_seen_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic                 halted_ff, halted_in;

   rsp_payload_type      rbuf_ff [4];
   rsp_payload_type      rbuf_in [4];
   logic [2:0]           left_ff;
   logic [2:0]           res_n;

   logic                 accept;
   logic                 pop;
   logic [7:0]           c;

   // Results from the current mode, then from starting a new token.
   rsp_payload_type      pre [2];
   logic [1:0]           pre_n;
   logic                 use_start;
   rsp_payload_type      st [2];
   logic [1:0]           st_n;
   logic [2:0]           st_mode;
   logic                 st_num_clear;
   logic                 esc_ok;
   logic [7:0]           esc_byte;

   assign c         = req_data.ch;
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (left_ff != 3'd0);
   assign rsp_data  = rbuf_ff[0];
   assign req_ready = (left_ff == 3'd0) || ((left_ff == 3'd1) && rsp_ready);

   // What a byte does when it arrives between tokens.
   always_comb begin
      st_mode      = M_IDLE;
      st_n         = 2'd0;
      st_num_clear = 1'b0;
      st[0]        = '0;
      st[1]        = '0;
      if (c inside {CH_SPACE, CH_TAB, CH_CR}) begin
         st_mode = M_IDLE;
      end else if (c == CH_HASH) begin
         st_mode = M_LCOMMENT;
      end else if (c == CH_LF) begin
         st[0] = make_rsp(K_CHAR, T_NL, CH_LF, 2'd0);
         st[1] = make_rsp(K_DONE, T_NL, 8'd0, 2'd0);
         st_n  = 2'd2;
      end else if (c == CH_SLASH) begin
         st_mode = M_SLASH;
      end else if (c == CH_QUOTE) begin
         st_mode = M_STRING;
      end else if (is_digit(c)) begin
         st_num_clear = 1'b1;
         st[0]        = make_rsp(K_CHAR, T_NUM, c, 2'd0);
         st_n         = 2'd1;
         st_mode      = M_NUMBER;
      end else if ((c == CH_UNDER) || is_alpha(c)) begin
         st[0]   = make_rsp(K_CHAR, T_IDENT, c, 2'd0);
         st_n    = 2'd1;
         st_mode = M_IDENT;
      end else begin
         st[0] = make_rsp(K_CHAR, T_OP, c, 2'd0);
         st[1] = make_rsp(K_DONE, T_OP, 8'd0, 2'd0);
         st_n  = 2'd2;
      end
   end

   // Escape letter translation.
   always_comb begin
      esc_ok   = 1'b1;
      esc_byte = c;
      case (c)
         CH_BSLASH, CH_SLASH, CH_QUOTE: esc_byte = c;
         CH_LO_B: esc_byte = CH_BS;
         CH_LO_F: esc_byte = CH_FF;
         CH_LO_N: esc_byte = CH_LF;
         CH_LO_R: esc_byte = CH_CR;
         CH_LO_T: esc_byte = CH_TAB;
         default: esc_ok = 1'b0;
      endcase
   end

   // Scanner: next state and the results of one request.
   always_comb begin
      mode_in      = mode_ff;
      seen_dot_in  = seen_dot_ff;
      seen_exp_in  = seen_exp_ff;
      sign_ok_in   = sign_ok_ff;
      star_seen_in = star_seen_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      halted_in    = halted_ff;
      pre[0]       = '0;
      pre[1]       = '0;
      pre_n        = 2'd0;
      use_start    = 1'b0;

      if (req_data.end_of_input) begin
         case (mode_ff)
            M_NUMBER: begin
               pre[0] = make_rsp(K_DONE, T_NUM, 8'd0, 2'd0);
               pre_n  = 2'd1;
            end
            M_IDENT: begin
               pre[0] = make_rsp(K_DONE, T_IDENT, 8'd0, 2'd0);
               pre_n  = 2'd1;
            end
            M_SLASH: begin
               pre[0] = make_rsp(K_CHAR, T_OP, CH_SLASH, 2'd0);
               pre[1] = make_rsp(K_DONE, T_OP, 8'd0, 2'd0);
               pre_n  = 2'd2;
            end
            M_STRING, M_ESCAPE: begin
               pre[0]    = make_rsp(K_ERROR, T_STR, 8'd0, E_OPEN_STRING);
               pre_n     = 2'd1;
               halted_in = 1'b1;
            end
            default: pre_n = 2'd0;
         endcase
         mode_in      = M_IDLE;
         seen_dot_in  = 1'b0;
         seen_exp_in  = 1'b0;
         sign_ok_in   = 1'b0;
         star_seen_in = 1'b0;
      end else begin
         if (c == CH_LF) begin
            if (!(&line_ff)) begin
               line_in = line_ff + 1'b1;
            end
            col_in = '0;
         end else if (!(&col_ff)) begin
            col_in = col_ff + 1'b1;
         end

         case (mode_ff)
            M_SLASH: begin
               if (c == CH_SLASH) begin
                  mode_in = M_LCOMMENT;
               end else if (c == CH_STAR) begin
                  mode_in      = M_BCOMMENT;
                  star_seen_in = 1'b0;
               end else begin
                  pre[0]    = make_rsp(K_CHAR, T_OP, CH_SLASH, 2'd0);
                  pre[1]    = make_rsp(K_DONE, T_OP, 8'd0, 2'd0);
                  pre_n     = 2'd2;
                  use_start = 1'b1;
               end
            end
            M_LCOMMENT: begin
               if (c == CH_LF) begin
                  mode_in = M_IDLE;
               end
            end
            M_BCOMMENT: begin
               if (star_seen_ff && (c == CH_SLASH)) begin
                  mode_in      = M_IDLE;
                  star_seen_in = 1'b0;
               end else begin
                  star_seen_in = (c == CH_STAR);
               end
            end
            M_STRING: begin
               if (c == CH_BSLASH) begin
                  mode_in = M_ESCAPE;
               end else if (c == CH_QUOTE) begin
                  pre[0]  = make_rsp(K_DONE, T_STR, 8'd0, 2'd0);
                  pre_n   = 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  pre[0] = make_rsp(K_CHAR, T_STR, c, 2'd0);
                  pre_n  = 2'd1;
               end
            end
            M_ESCAPE: begin
               mode_in = M_STRING;
               pre_n   = 2'd1;
               if (esc_ok) begin
                  pre[0] = make_rsp(K_CHAR, T_STR, esc_byte, 2'd0);
               end else begin
                  pre[0]    = make_rsp(K_ERROR, T_STR, 8'd0, E_BAD_ESCAPE);
                  halted_in = 1'b1;
               end
            end
            M_NUMBER: begin
               sign_ok_in = 1'b0;
               pre_n      = 2'd1;
               if (sign_ok_ff && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                  pre[0] = make_rsp(K_CHAR, T_NUM, c, 2'd0);
               end else if (c == CH_DOT) begin
                  if (seen_dot_ff || seen_exp_ff) begin
                     pre[0]    = make_rsp(K_ERROR, T_NUM, 8'd0, E_BAD_NUMBER);
                     halted_in = 1'b1;
                  end else begin
                     seen_dot_in = 1'b1;
                     pre[0]      = make_rsp(K_CHAR, T_NUM, c, 2'd0);
                  end
               end else if ((c == CH_LO_E) || (c == CH_UP_E)) begin
                  if (seen_exp_ff) begin
                     pre[0]    = make_rsp(K_ERROR, T_NUM, 8'd0, E_BAD_NUMBER);
                     halted_in = 1'b1;
                  end else begin
                     seen_exp_in = 1'b1;
                     sign_ok_in  = 1'b1;
                     pre[0]      = make_rsp(K_CHAR, T_NUM, c, 2'd0);
                  end
               end else if (is_digit(c)) begin
                  pre[0] = make_rsp(K_CHAR, T_NUM, c, 2'd0);
               end else begin
                  pre[0]    = make_rsp(K_DONE, T_NUM, 8'd0, 2'd0);
                  use_start = 1'b1;
               end
            end
            M_IDENT: begin
               pre_n = 2'd1;
               if ((c == CH_UNDER) || is_alpha(c) || is_digit(c)) begin
                  pre[0] = make_rsp(K_CHAR, T_IDENT, c, 2'd0);
               end else begin
                  pre[0]    = make_rsp(K_DONE, T_IDENT, 8'd0, 2'd0);
                  use_start = 1'b1;
               end
            end
            default: use_start = 1'b1;
         endcase

         if (use_start) begin
            mode_in = st_mode;
            if (st_num_clear) begin
               seen_dot_in = 1'b0;
               seen_exp_in = 1'b0;
               sign_ok_in  = 1'b0;
            end
         end
      end
   end

   // Pack the results into buffer order and stamp position and run end.
   always_comb begin
      res_n = 3'd0;
      for (int i = 0; i < 4; i++) begin
         rbuf_in[i] = '0;
      end
      for (int i = 0; i < 2; i++) begin
         if (2'(i) < pre_n) begin
            rbuf_in[res_n[1:0]] = pre[i];
            res_n               = res_n + 3'd1;
         end
      end
      if (use_start) begin
         for (int i = 0; i < 2; i++) begin
            if (2'(i) < st_n) begin
               rbuf_in[res_n[1:0]] = st[i];
               res_n               = res_n + 3'd1;
            end
         end
      end
      for (int i = 0; i < 4; i++) begin
         rbuf_in[i].line_no     = line_in;
         rbuf_in[i].col_no      = col_in;
         rbuf_in[i].last_of_run = ((3'(i) + 3'd1) == res_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_IDLE;
         seen_dot_ff  <= 1'b0;
         seen_exp_ff  <= 1'b0;
         sign_ok_ff   <= 1'b0;
         star_seen_ff <= 1'b0;
         line_ff      <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         col_ff       <= '0;
         halted_ff    <= 1'b0;
      end else if (accept && !halted_ff) begin
         mode_ff      <= mode_in;
         seen_dot_ff  <= seen_dot_in;
         seen_exp_ff  <= seen_exp_in;
         sign_ok_ff   <= sign_ok_in;
         star_seen_ff <= star_seen_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         halted_ff    <= halted_in;
      end
   end

   // A request is taken only when the buffer is empty or hands out its last result.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 3'd0;
      end else if (accept) begin
         left_ff <= halted_ff ? 3'd0 : res_n;
      end else if (pop) begin
         left_ff <= left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 4; i++) begin
            rbuf_ff[i] <= rbuf_in[i];
         end
      end else if (pop) begin
         for (int i = 0; i < 3; i++) begin
            rbuf_ff[i] <= rbuf_ff[i+1];
         end
      end
   end

   `TTOK_ASSERT_NOW(a_no_overrun, clock, reset, accept,
      (left_ff == 3'd0) || ((left_ff == 3'd1) && rsp_ready),
      "request taken while earlier results are still queued")

   `TTOK_ASSERT_NEXT(a_halt_sticks, clock, reset, halted_ff, halted_ff,
      "tokenizer left the error stop without reset")

   `TTOK_ASSERT_NOW(a_error_last, clock, reset,
      rsp_valid && (rsp_data.kind == K_ERROR), rsp_data.last_of_run,
      "error result is not the last of its run")

   `TTOK_ASSERT_NEXT(a_line_monotonic, clock, reset, 1'b1, line_ff >= $past(line_ff),
      "line number went backward")

endmodule

/* tb/text_tokenizer_checker.sv */
// Checker for text_tokenizer: watches the request and result channels, predicts
// the token events of each accepted request and compares them. Depends on ttok_pkg.
`timescale 1ns / 100ps

module text_tokenizer_checker
   import ttok_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data,
   output int              failures,
   output int              pending
);

   localparam logic [1:0] NO_ERROR   = 2'd0;
   localparam int         MAX_EVENTS = 4;

   logic [2:0]           scan_state;
   logic                 num_dot, num_exp, num_sign_ok, star_pending, stopped;
   logic [LINE_BITS-1:0] line_pos;
   logic [COL_BITS-1:0]  col_pos;

   rsp_payload_type step_events[$];
   rsp_payload_type token_events_due[$];

   function automatic logic is_decimal(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
   endfunction

   // Every event carries the position after the current byte has been counted.
   function automatic void note_event(input logic [1:0] kind, input logic [2:0] ttype,
                                      input logic [7:0] tbyte, input logic [1:0] err);
      rsp_payload_type ev;
      ev.kind        = kind;
      ev.token_type  = ttype;
      ev.text_byte   = tbyte;
      ev.error_code  = err;
      ev.line_no     = line_pos;
      ev.col_no      = col_pos;
      ev.last_of_run = 1'b0;
      if (step_events.size() < MAX_EVENTS) step_events.push_back(ev);
   endfunction

   function automatic void halt_on(input logic [2:0] ttype, input logic [1:0] err);
      note_event(K_ERROR, ttype, 8'h00, err);
      stopped = 1'b1;
   endfunction

   function automatic void begin_token(input logic [7:0] c);
      scan_state = M_IDLE;
      if (c == CH_HASH) begin
         scan_state = M_LCOMMENT;
      end else if (c == CH_LF) begin
         note_event(K_CHAR, T_NL, c, NO_ERROR);
         note_event(K_DONE, T_NL, 8'h00, NO_ERROR);
      end else if (c == CH_SLASH) begin
         scan_state = M_SLASH;
      end else if (c == CH_QUOTE) begin
         scan_state = M_STRING;
      end else if (is_decimal(c)) begin
         num_dot     = 1'b0;
         num_exp     = 1'b0;
         num_sign_ok = 1'b0;
         note_event(K_CHAR, T_NUM, c, NO_ERROR);
         scan_state = M_NUMBER;
      end else if (c == CH_UNDER || is_letter(c)) begin
         note_event(K_CHAR, T_IDENT, c, NO_ERROR);
         scan_state = M_IDENT;
      end else if (c != CH_SPACE && c != CH_TAB && c != CH_CR) begin
         note_event(K_CHAR, T_OP, c, NO_ERROR);
         note_event(K_DONE, T_OP, 8'h00, NO_ERROR);
      end
   endfunction

   function automatic void number_char(input logic [7:0] c);
      logic sign_ok;
      sign_ok     = num_sign_ok;
      num_sign_ok = 1'b0;
      if (sign_ok && (c == CH_PLUS || c == CH_MINUS)) begin
         note_event(K_CHAR, T_NUM, c, NO_ERROR);
      end else if (c == CH_DOT) begin
         if (num_dot || num_exp) begin
            halt_on(T_NUM, E_BAD_NUMBER);
         end else begin
            num_dot = 1'b1;
            note_event(K_CHAR, T_NUM, c, NO_ERROR);
         end
      end else if (c == CH_LO_E || c == CH_UP_E) begin
         if (num_exp) begin
            halt_on(T_NUM, E_BAD_NUMBER);
         end else begin
            num_exp     = 1'b1;
            num_sign_ok = 1'b1;
            note_event(K_CHAR, T_NUM, c, NO_ERROR);
         end
      end else if (is_decimal(c)) begin
         note_event(K_CHAR, T_NUM, c, NO_ERROR);
      end else begin
         note_event(K_DONE, T_NUM, 8'h00, NO_ERROR);
         begin_token(c);
      end
   endfunction

   function automatic void escape_char(input logic [7:0] c);
      logic [7:0] xlat;
      logic       known;
      scan_state = M_STRING;
      known      = 1'b1;
      case (c)
         CH_BSLASH, CH_SLASH, CH_QUOTE: xlat = c;
         CH_LO_B: xlat = CH_BS;
         CH_LO_F: xlat = CH_FF;
         CH_LO_N: xlat = CH_LF;
         CH_LO_R: xlat = CH_CR;
         CH_LO_T: xlat = CH_TAB;
         default: begin
            xlat  = 8'h00;
            known = 1'b0;
         end
      endcase
      if (known) note_event(K_CHAR, T_STR, xlat, NO_ERROR);
      else halt_on(T_STR, E_BAD_ESCAPE);
   endfunction

   function automatic void close_input();
      case (scan_state)
         M_NUMBER: note_event(K_DONE, T_NUM, 8'h00, NO_ERROR);
         M_IDENT: note_event(K_DONE, T_IDENT, 8'h00, NO_ERROR);
         M_SLASH: begin
            note_event(K_CHAR, T_OP, CH_SLASH, NO_ERROR);
            note_event(K_DONE, T_OP, 8'h00, NO_ERROR);
         end
         M_STRING, M_ESCAPE: halt_on(T_STR, E_OPEN_STRING);
         default: ;
      endcase
      scan_state   = M_IDLE;
      num_dot      = 1'b0;
      num_exp      = 1'b0;
      num_sign_ok  = 1'b0;
      star_pending = 1'b0;
   endfunction

   function automatic void scan_byte(input logic [7:0] c);
      if (c == CH_LF) begin
         if (line_pos != '1) line_pos++;
         col_pos = '0;
      end else if (col_pos != '1) begin
         col_pos++;
      end
      case (scan_state)
         M_SLASH: begin
            if (c == CH_SLASH) begin
               scan_state = M_LCOMMENT;
            end else if (c == CH_STAR) begin
               scan_state   = M_BCOMMENT;
               star_pending = 1'b0;
            end else begin
               note_event(K_CHAR, T_OP, CH_SLASH, NO_ERROR);
               note_event(K_DONE, T_OP, 8'h00, NO_ERROR);
               begin_token(c);
            end
         end
         M_LCOMMENT: begin
            if (c == CH_LF) scan_state = M_IDLE;
         end
         M_BCOMMENT: begin
            if (star_pending && c == CH_SLASH) begin
               scan_state   = M_IDLE;
               star_pending = 1'b0;
            end else begin
               star_pending = (c == CH_STAR);
            end
         end
         M_STRING: begin
            if (c == CH_BSLASH) begin
               scan_state = M_ESCAPE;
            end else if (c == CH_QUOTE) begin
               note_event(K_DONE, T_STR, 8'h00, NO_ERROR);
               scan_state = M_IDLE;
            end else begin
               note_event(K_CHAR, T_STR, c, NO_ERROR);
            end
         end
         M_ESCAPE: escape_char(c);
         M_NUMBER: number_char(c);
         M_IDENT: begin
            if (c == CH_UNDER || is_letter(c) || is_decimal(c)) begin
               note_event(K_CHAR, T_IDENT, c, NO_ERROR);
            end else begin
               note_event(K_DONE, T_IDENT, 8'h00, NO_ERROR);
               begin_token(c);
            end
         end
         default: begin_token(c);
      endcase
   endfunction

   function automatic void predict_request(input req_payload_type req);
      rsp_payload_type tail;
      step_events.delete();
      if (!stopped) begin
         if (req.end_of_input) close_input();
         else scan_byte(req.ch);
         if (step_events.size() != 0) begin
            tail             = step_events.pop_back();
            tail.last_of_run = 1'b1;
            step_events.push_back(tail);
         end
      end
      foreach (step_events[i]) token_events_due.push_back(step_events[i]);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         scan_state   = M_IDLE;
         num_dot      = 1'b0;
         num_exp      = 1'b0;
         num_sign_ok  = 1'b0;
         star_pending = 1'b0;
         stopped      = 1'b0;
         line_pos     = 1;
         col_pos      = '0;
         failures     = 0;
         token_events_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (token_events_due.size() == 0) begin
               $display("%0t: result with none expected, expected nothing, got %h",
                        $time, rsp_data);
               failures++;
            end else begin
               want = token_events_due.pop_front();
               check_field("kind", want.kind, rsp_data.kind);
               check_field("token_type", want.token_type, rsp_data.token_type);
               check_field("text_byte", want.text_byte, rsp_data.text_byte);
               check_field("error_code", want.error_code, rsp_data.error_code);
               check_field("line_no", want.line_no, rsp_data.line_no);
               check_field("col_no", want.col_no, rsp_data.col_no);
               check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
            end
         end
         if (req_valid && req_ready) predict_request(req_data);
      end
      pending = token_events_due.size();
   end

endmodule

/* tb/text_tokenizer_test.sv */
// Top of the text_tokenizer testbench: clock, reset, source text and result stalls.
// Instantiates the block and text_tokenizer_checker; depends on ttok_pkg.
`timescale 1ns / 100ps

module text_tokenizer_test;
   import ttok_pkg::*;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_QUARTER,
      READY_MOSTLY
   } ready_style_type;

   // Bit 8 set marks an end-of-input request; the low byte then goes out as noise.
   typedef logic [8:0] source_unit_type;

   localparam int              RANDOM_TOKEN_BYTES = 250;
   localparam source_unit_type END_MARK           = 9'h100;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   int              failures;
   int              pending;

   int              burst_left  = 0;
   int              token_bytes = 0;
   ready_style_type ready_style = READY_ALWAYS;
   int              style_left  = 0;
   logic [2:0]      ready_tick  = '0;
   source_unit_type source_buf[$];

   always #10 clock = ~clock;

   text_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   text_tokenizer_checker event_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   always @(posedge clock) begin
      if (style_left == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 3));
         style_left  = $urandom_range(32, 200);
      end
      style_left--;
      ready_tick++;
      case (ready_style)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
         READY_QUARTER: rsp_ready <= (ready_tick[1:0] == 2'b00);
         default: rsp_ready <= (ready_tick != 3'd3);
      endcase
   end

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_LO_A && c <= CH_LO_Z) ||
             (c >= CH_UP_A && c <= CH_UP_Z) || c == CH_UNDER;
   endfunction

   function automatic logic [7:0] pick_digit();
      return CH_0 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 2))
         0: return CH_SPACE;
         1: return CH_TAB;
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] pick_other(input logic [7:0] skip_a, input logic [7:0] skip_b);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == skip_a || c == skip_b);
      return c;
   endfunction

   // A byte that starts a one-character operator token between tokens.
   function automatic logic [7:0] pick_operator();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_HASH ||
             c == CH_SLASH || c == CH_QUOTE || is_word_char(c));
      return c;
   endfunction

   function automatic logic [7:0] pick_ident_char(input bit first);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (!is_word_char(c) || (first && c >= CH_0 && c <= CH_9));
      return c;
   endfunction

   function automatic logic [7:0] pick_escape_letter();
      case ($urandom_range(0, 7))
         0: return CH_BSLASH;
         1: return CH_SLASH;
         2: return CH_QUOTE;
         3: return CH_LO_B;
         4: return CH_LO_F;
         5: return CH_LO_N;
         6: return CH_LO_R;
         default: return CH_LO_T;
      endcase
   endfunction

   function automatic logic [7:0] pick_bad_escape();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CH_BSLASH || c == CH_SLASH || c == CH_QUOTE || c == CH_LO_B ||
             c == CH_LO_F || c == CH_LO_N || c == CH_LO_R || c == CH_LO_T);
      return c;
   endfunction

   // Ends a number so that the next token cannot extend it into a bad number.
   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 7))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_CR;
         3: return CH_LF;
         4: return ",";
         5: return ";";
         6: return "x";
         default: return CH_UNDER;
      endcase
   endfunction

   function automatic void add_byte(input logic [7:0] c);
      source_buf.push_back({1'b0, c});
   endfunction

   function automatic void add_end();
      source_buf.push_back(END_MARK | source_unit_type'($urandom_range(0, 255)));
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   // Sometimes the source ends inside a token; what follows starts afresh.
   function automatic void cut_token(input int first);
      if ($urandom_range(0, 9) == 0)
         source_buf.insert($urandom_range(first + 1, source_buf.size()),
                           END_MARK | source_unit_type'($urandom_range(0, 255)));
   endfunction

   function automatic void add_number();
      int first;
      first = source_buf.size();
      repeat ($urandom_range(1, 3)) add_byte(pick_digit());
      if ($urandom_range(0, 1) == 1) begin
         add_byte(CH_DOT);
         repeat ($urandom_range(0, 2)) add_byte(pick_digit());
      end
      if ($urandom_range(0, 4) < 2) begin
         add_byte(($urandom_range(0, 1) == 1) ? CH_LO_E : CH_UP_E);
         if ($urandom_range(0, 1) == 1)
            add_byte(($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS);
         repeat ($urandom_range(0, 2)) add_byte(pick_digit());
      end
      cut_token(first);
      add_byte(pick_separator());
   endfunction

   function automatic void add_ident();
      int first;
      first = source_buf.size();
      add_byte(pick_ident_char(1'b1));
      repeat ($urandom_range(0, 4)) add_byte(pick_ident_char(1'b0));
      cut_token(first);
   endfunction

   function automatic void add_string();
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 3) == 0) begin
            add_byte(CH_BSLASH);
            add_byte(pick_escape_letter());
         end else begin
            add_byte(pick_other(CH_QUOTE, CH_BSLASH));
         end
      end
      add_byte(CH_QUOTE);
   endfunction

   function automatic void add_line_comment();
      if ($urandom_range(0, 1) == 1) add_byte(CH_HASH);
      else add_text("//");
      repeat ($urandom_range(0, 5)) add_byte(pick_other(CH_LF, CH_LF));
      if ($urandom_range(0, 6) == 0) add_end();
      else add_byte(CH_LF);
   endfunction

   function automatic void add_block_comment();
      add_text("/*");
      repeat ($urandom_range(0, 6)) add_byte(pick_other(CH_SLASH, CH_SLASH));
      if ($urandom_range(0, 6) == 0) add_end();
      else add_text("*/");
   endfunction

   function automatic void add_lone_slash();
      add_byte(CH_SLASH);
      case ($urandom_range(0, 3))
         0: add_end();
         1: add_byte(CH_LF);
         2: add_byte(";");
         default: add_byte(pick_blank());
      endcase
   endfunction

   // Returns whether the token is one that the block reports.
   function automatic bit add_random_token();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         add_byte(pick_blank());
         return 1'b0;
      end else if (pick < 18) begin
         add_byte(CH_LF);
      end else if (pick < 36) begin
         add_number();
      end else if (pick < 51) begin
         add_ident();
      end else if (pick < 66) begin
         add_string();
      end else if (pick < 78) begin
         add_byte(pick_operator());
      end else if (pick < 84) begin
         add_line_comment();
         return 1'b0;
      end else if (pick < 89) begin
         add_block_comment();
         return 1'b0;
      end else if (pick < 95) begin
         add_lone_slash();
      end else begin
         add_end();
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // One request; returns in the time step of its handshake.
   task automatic send_unit(input source_unit_type unit);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= {unit[7:0], unit[8]};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic flush_source(input bit counted);
      if (counted) token_bytes += source_buf.size();
      while (source_buf.size() != 0) send_unit(source_buf.pop_front());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   initial begin
      bit paused;
      bit counted;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Extremes of the byte, a number closed by an operator, tokens closed by the
      // end of input, comments, an escape and a newline token.
      add_byte(8'h00);
      add_byte(8'hFF);
      add_text("12.5e-3;");
      add_text("_x");
      add_end();
      add_byte(CH_SLASH);
      add_end();
      add_text("/*/**/#\n");
      add_text("\"a\\t\"\n");
      flush_source(1'b1);

      while (token_bytes < RANDOM_TOKEN_BYTES) begin
         counted = add_random_token();
         flush_source(counted);
         if (!paused && token_bytes >= RANDOM_TOKEN_BYTES / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      // Any error stops the block for good, so exactly one ends the run.
      wait_drained();
      add_byte(CH_SPACE);
      case ($urandom_range(0, 5))
         0: add_text("7.2.");
         1: add_text("5e1.");
         2: add_text("9E2e");
         3: begin
            add_text("\"a\\");
            add_byte(pick_bad_escape());
         end
         4: begin
            add_text("\"ab");
            add_end();
         end
         default: begin
            add_text("\"\\");
            add_end();
         end
      endcase
      repeat (6) begin
         if ($urandom_range(0, 2) == 0) add_end();
         else add_byte(8'($urandom_range(0, 255)));
      end
      flush_source(1'b0);
      req_valid <= 1'b0;

      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
